@@ src/kwss_pkg.sv @@
// ----------------------------------------------------------------------------
// kwss_pkg: shared types and constants of the keyword spam scorer
// Command codes, field widths, table sizes and the queue entry between
// front and back.
// ----------------------------------------------------------------------------
package kwss_pkg;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int PTS_W    = 16;
    localparam int SCORE_W  = 20;
    localparam int THRESH_W = 31;

    // Table size, tied to the slot and position field widths
    localparam int WORDS    = 16;
    localparam int MAX_LEN  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // One item as classified by the front end
    typedef struct packed {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   char_pos;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
        logic [PTS_W-1:0]   points;
    } t_item;

    // Fold 'A'..'Z' onto 'a'..'z', pass every other byte
    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/kwss_front.sv @@
// ----------------------------------------------------------------------------
// kwss_front: input stage and item queue
// Lowercase the byte, drop ignored items and hold accepted ones in a
// small queue for the back end.
// ----------------------------------------------------------------------------
module kwss_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  kwss_pkg::t_item               i_item,
    output logic                          o_valid,
    output kwss_pkg::t_item               o_item,
    input  logic                          i_take
);
    localparam int DEPTH   = 4;
    localparam int WORDS   = kwss_pkg::WORDS;
    localparam int MAX_LEN = kwss_pkg::MAX_LEN;

    kwss_pkg::t_item  r_q [DEPTH];
    logic [1:0]       r_wp, r_rp;
    logic [2:0]       r_cnt;
    logic             keep;
    kwss_pkg::t_item  cls;
    logic             wr, rd;

    // Classify: lowercase, and keep only items that change state
    always_comb begin
        cls = i_item;
        cls.data_byte = kwss_pkg::to_lower(i_item.data_byte);
        keep = 1'b1;
        case (i_item.cmd)
            kwss_pkg::CMD_LOAD: keep = ({1'b0, i_item.slot} < 5'(WORDS))
                                   && ({1'b0, i_item.char_pos} < 5'(MAX_LEN));
            kwss_pkg::CMD_NONE: keep = 1'b0;
            default:            keep = 1'b1;
        endcase
    end

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[r_rp];
    assign wr      = i_push && !o_full && keep;
    assign rd      = i_take && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end

    // Hold the queue payload
    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= cls;
    end
endmodule

@@ src/kwss_back.sv @@
// ----------------------------------------------------------------------------
// kwss_back: keyword table, message window and scoring
// Carry out one item a cycle while running; on the last message byte sum
// the points of found keywords one slot per cycle and queue the result.
// ----------------------------------------------------------------------------
module kwss_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [kwss_pkg::THRESH_W-1:0]   i_thresh,
    input  logic                            i_valid,
    input  kwss_pkg::t_item                 i_item,
    output logic                            o_take,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic                            o_is_spam,
    output logic [kwss_pkg::SCORE_W-1:0]    o_score
);
    localparam int WORDS   = kwss_pkg::WORDS;
    localparam int MAX_LEN = kwss_pkg::MAX_LEN;
    localparam int SW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SUMW = kwss_pkg::PTS_W + SW + 1;

    typedef enum logic [1:0] { ST_RUN, ST_SUM, ST_OUT } t_state;

    logic [7:0]                 r_chars [WORDS][MAX_LEN];
    logic [LW-1:0]              r_len   [WORDS];
    logic [kwss_pkg::PTS_W-1:0] r_pts   [WORDS];
    logic [7:0]                 r_win   [MAX_LEN];
    logic [LW-1:0]              r_seen;
    logic [WORDS-1:0]           r_found;
    t_state                     r_state;
    logic [SW-1:0]              r_idx;
    logic [SUMW-1:0]            r_sum;
    logic                       r_oval;
    logic [WORDS-1:0]           hit;
    logic [7:0]                 win_n [MAX_LEN];
    logic [LW-1:0]              seen_n;
    logic                       do_msg;

    assign o_take  = (r_state == ST_RUN) && i_valid;
    assign o_empty = !r_oval;
    assign do_msg  = o_take && (i_item.cmd == kwss_pkg::CMD_MSG);

    // Window after the new byte
    always_comb begin
        win_n[0] = i_item.data_byte;
        for (int i = 1; i < MAX_LEN; i++) win_n[i] = r_win[i-1];
        seen_n = (r_seen < LW'(MAX_LEN)) ? r_seen + LW'(1) : r_seen;
    end

    // Match every slot against the shifted window, all lanes in parallel
    always_comb begin
        for (int s = 0; s < WORDS; s++) begin
            hit[s] = (r_len[s] != '0) && (r_len[s] <= seen_n);
            for (int i = 0; i < MAX_LEN; i++) begin
                if (LW'(i) < r_len[s]
                    && r_chars[s][i] != win_n[IW'(r_len[s] - LW'(i) - LW'(1))])
                    hit[s] = 1'b0;
            end
        end
    end

    // Keyword characters: no reset
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.cmd == kwss_pkg::CMD_LOAD)
            r_chars[i_item.slot][i_item.char_pos] <= i_item.data_byte;
    end

    // Shift the window on a message byte, clear it between messages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.cmd == kwss_pkg::CMD_CLEAR)
            || r_state == ST_OUT) begin
            for (int i = 0; i < MAX_LEN; i++) r_win[i] <= '0;
        end else if (do_msg) begin
            for (int i = 0; i < MAX_LEN; i++) r_win[i] <= win_n[i];
        end
    end

    // Control, table and scoring sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_seen  <= '0;
            r_found <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_oval  <= 1'b0;
            for (int s = 0; s < WORDS; s++) begin
                r_len[s] <= '0;
                r_pts[s] <= '0;
            end
        end else begin
            // Drop the taken result unless a new one replaces it below
            if (i_pop && r_oval && r_state != ST_OUT) r_oval <= 1'b0;
            case (r_state)
                ST_RUN: begin
                    if (o_take) begin
                        case (i_item.cmd)
                            kwss_pkg::CMD_CLEAR: begin
                                for (int s = 0; s < WORDS; s++) begin
                                    r_len[s] <= '0;
                                    r_pts[s] <= '0;
                                end
                                r_found <= '0;
                                r_seen  <= '0;
                            end
                            kwss_pkg::CMD_LOAD: begin
                                if (i_item.last) begin
                                    r_len[i_item.slot] <= LW'(i_item.char_pos) + LW'(1);
                                    r_pts[i_item.slot] <= i_item.points;
                                end else begin
                                    r_len[i_item.slot] <= '0;
                                end
                            end
                            kwss_pkg::CMD_MSG: begin
                                r_seen  <= seen_n;
                                r_found <= r_found | hit;
                                if (i_item.last) begin
                                    r_state <= ST_SUM;
                                    r_idx   <= '0;
                                    r_sum   <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SUM: begin
                    if (r_found[r_idx]) r_sum <= r_sum + SUMW'(r_pts[r_idx]);
                    if (r_idx == SW'(WORDS - 1)) r_state <= ST_OUT;
                    else r_idx <= r_idx + SW'(1);
                end
                ST_OUT: begin
                    if (!r_oval || i_pop) begin
                        r_oval    <= 1'b1;
                        o_is_spam <= (kwss_pkg::THRESH_W'(r_sum) >= i_thresh);
                        o_score   <= (r_sum > SUMW'(20'hFFFFF)) ? 20'hFFFFF
                                                                : r_sum[19:0];
                        r_found   <= '0;
                        r_seen    <= '0;
                        r_state   <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end
endmodule

@@ src/keyword_weighted_spam_scorer_unit.sv @@
// Path: a last message byte waits in the front queue, then the back end sums the points
// of found slots one slot at a time and registers the result in its output stage.
// Throughput: one item per cycle while not full; after each last byte the back end takes
// nothing while it sums, and longer while an earlier result waits to be popped.
// Reset (i_rst_n low, synchronous): empty table, window and queues, threshold 1.
// ----------------------------------------------------------------------------
// keyword_weighted_spam_scorer_unit: top level
// Keyword table loader and message scorer with a queue on each side.
// ----------------------------------------------------------------------------
module keyword_weighted_spam_scorer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   i_cmd,
    input  logic [3:0]   i_slot,
    input  logic [3:0]   i_char_pos,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last,
    input  logic [15:0]  i_points,
    output logic         empty,
    input  logic         pop,
    output logic         o_is_spam,
    output logic [19:0]  o_score,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_data
);
    logic [30:0]     r_thresh;
    kwss_pkg::t_item in_item, q_item;
    logic            q_valid, q_take;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thresh <= 31'd1;
        else if (i_cfg_we) r_thresh <= i_cfg_data;
    end

    always_comb begin
        in_item.cmd       = kwss_pkg::t_cmd'(i_cmd);
        in_item.slot      = i_slot;
        in_item.char_pos  = i_char_pos;
        in_item.data_byte = i_data_byte;
        in_item.last      = i_last;
        in_item.points    = i_points;
    end

    kwss_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(in_item), .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    kwss_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_thresh(r_thresh),
        .i_valid(q_valid), .i_item(q_item), .o_take(q_take),
        .o_empty(empty), .i_pop(pop), .o_is_spam(o_is_spam), .o_score(o_score)
    );
endmodule

@@ src/kwss_checker.sv @@
// ----------------------------------------------------------------------------
// kwss_checker: port-level checks of the spam scorer
// Watches the result queue handshake on the top level.
// ----------------------------------------------------------------------------
module kwss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_is_spam,
    input logic [19:0] o_score
);
    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_score) && $stable(o_is_spam)))
        else $error("result changed while waiting");

    // Nothing to show straight after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // A shown result carries known values
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_is_spam, o_score}))
        else $error("result has unknown bits");
endmodule

bind keyword_weighted_spam_scorer_unit kwss_checker u_kwss_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_is_spam(o_is_spam), .o_score(o_score)
);
